>>> rtl/odfm_pkg.sv
// ----------------------------------------------------------------------------
// odfm_pkg
// Shared types and constants of the occupancy dilation foreground mask unit.
// ----------------------------------------------------------------------------
package odfm_pkg;

  // Default sizes of the static map and the inflation window
  localparam int unsigned MAX_WIDTH_DEF  = 256;
  localparam int unsigned MAX_HEIGHT_DEF = 256;
  localparam int unsigned MAX_RADIUS_DEF = 15;

  // Item kinds
  localparam logic [1:0] KIND_LOAD    = 2'd0;
  localparam logic [1:0] KIND_INFLATE = 2'd1;
  localparam logic [1:0] KIND_QUERY   = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 2'd3;

  // Register reset values
  localparam logic       ENABLE_RST     = 1'b1;
  localparam logic [3:0] RADIUS_RST     = 4'd8;
  localparam logic [8:0] MAP_WIDTH_RST  = 9'd256;
  localparam logic [8:0] MAP_HEIGHT_RST = 9'd256;

  // Cost and occupancy constants
  localparam logic signed [7:0] OBSTACLE_VALUE     = 8'sd100;
  localparam logic [7:0]        LETHAL_THRESHOLD   = 8'd90;
  localparam logic [7:0]        INFLATED_THRESHOLD = 8'd50;
  localparam logic [7:0]        MARK_VALUE         = 8'd100;
  localparam logic [7:0]        COST_LETHAL        = 8'd254;
  localparam logic [7:0]        COST_FREE          = 8'd0;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] map_x;
    logic signed [15:0] map_y;
    logic signed [7:0]  cell_value;
    logic [7:0]         master_cost;
  } item_t;

  typedef struct packed {
    logic [7:0] new_cost;
    logic       inflate_done;
  } res_t;

endpackage

>>> rtl/occupancy_dilate_foreground_mask_unit.sv
// ----------------------------------------------------------------------------
// occupancy_dilate_foreground_mask_unit
// Static occupancy map with square dilation and foreground masking of costs.
// ----------------------------------------------------------------------------
// Loads and queries are taken one per cycle while busy_o is low; a query's
// result strobes in the cycle after it is taken, a load gives none. An inflate
// of a w x h map with radius r keeps busy_o high over a row and a column pass:
// each pass walks every line through the single read port of its memory, one
// cell a cycle, going r cells past each line's end to flush the sliding window.
// The done word strobes in the cycle busy_o falls (or in the next cycle for an
// empty map, with busy_o staying low). Results are shown for one cycle only and
// must be taken then: there is no way to hold them off. No clearing pass follows
// reset; marks outside the last inflated map size read as clear.
// ----------------------------------------------------------------------------
module occupancy_dilate_foreground_mask_unit #(
  parameter int unsigned MAX_WIDTH  = odfm_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = odfm_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned MAX_RADIUS = odfm_pkg::MAX_RADIUS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  odfm_pkg::item_t                   item_i,
  output logic                              res_valid_o,
  output odfm_pkg::res_t                    res_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [odfm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [odfm_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import odfm_pkg::*;

  localparam int unsigned XW  = $clog2(MAX_WIDTH);
  localparam int unsigned YW  = $clog2(MAX_HEIGHT);
  localparam int unsigned AW  = XW + YW;
  localparam int unsigned DWW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned DWH = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RW  = $clog2(MAX_RADIUS + 1);
  localparam int unsigned CW  = RW + 1;
  localparam int unsigned DWM = (DWW > DWH) ? DWW : DWH;
  localparam int unsigned TW  = ((DWM > RW) ? DWM : RW) + 1;
  localparam int unsigned LNW = (XW > YW) ? XW : YW;

  typedef enum logic [4:0] {
    ST_IDLE      = 5'b00001,
    ST_ROW       = 5'b00010,
    ST_ROW_FLUSH = 5'b00100,
    ST_COL       = 5'b01000,
    ST_COL_FLUSH = 5'b10000
  } state_e;

  // Configuration registers
  logic       enable_q;
  logic [3:0] radius_q;
  logic [8:0] map_width_q;
  logic [8:0] map_height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= ENABLE_RST;
      radius_q     <= RADIUS_RST;
      map_width_q  <= MAP_WIDTH_RST;
      map_height_q <= MAP_HEIGHT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_ENABLE:     enable_q     <= cfg_data_i[0];
        REG_RADIUS:     radius_q     <= cfg_data_i[3:0];
        REG_MAP_WIDTH:  map_width_q  <= cfg_data_i;
        REG_MAP_HEIGHT: map_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Saturated sizes in use
  logic [DWW-1:0] eff_w;
  logic [DWH-1:0] eff_h;
  logic [RW-1:0]  eff_r;

  assign eff_w = (32'(map_width_q) > MAX_WIDTH) ? DWW'(MAX_WIDTH) : DWW'(map_width_q);
  assign eff_h = (32'(map_height_q) > MAX_HEIGHT) ? DWH'(MAX_HEIGHT) : DWH'(map_height_q);
  assign eff_r = (32'(radius_q) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius_q);

  // Item decode
  logic          accept;
  logic          item_in_map;
  logic          item_in_infl;
  logic [AW-1:0] item_addr;

  state_e         state_q, state_d;
  logic [DWW-1:0] infl_w_q;
  logic [DWH-1:0] infl_h_q;
  logic [RW-1:0]  r_q;
  logic           map_ready_q;

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;

  assign item_in_map  = (32'($unsigned(item_i.map_x)) < 32'(eff_w)) &&
                        (32'($unsigned(item_i.map_y)) < 32'(eff_h));
  assign item_in_infl = (32'($unsigned(item_i.map_x)) < 32'(infl_w_q)) &&
                        (32'($unsigned(item_i.map_y)) < 32'(infl_h_q));
  assign item_addr    = {item_i.map_y[YW-1:0], item_i.map_x[XW-1:0]};

  // Sliding window sequencer
  logic [TW-1:0]  t_q, t_d;
  logic [LNW-1:0] line_q, line_d;
  logic           done_q, done_d;
  logic           map_ready_d;
  logic           col_pass;
  logic           issue;
  logic [TW-1:0]  len;
  logic [TW-1:0]  lines_m1;
  logic [TW-1:0]  last_t;
  logic           start_infl;
  logic           empty_map;

  assign col_pass   = (state_q == ST_COL);
  assign issue      = (state_q == ST_ROW) || col_pass;
  assign len        = col_pass ? TW'(infl_h_q) : TW'(infl_w_q);
  assign lines_m1   = col_pass ? TW'(infl_w_q) - 1'b1 : TW'(infl_h_q) - 1'b1;
  assign last_t     = len - 1'b1 + TW'(r_q);
  assign start_infl = accept && (item_i.kind == KIND_INFLATE);
  assign empty_map  = (eff_w == '0) || (eff_h == '0);

  always_comb begin
    state_d     = state_q;
    t_d         = t_q;
    line_d      = line_q;
    done_d      = 1'b0;
    map_ready_d = map_ready_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_infl) begin
          t_d    = '0;
          line_d = '0;
          if (empty_map) begin
            done_d      = 1'b1;
            map_ready_d = 1'b1;
          end else begin
            state_d = ST_ROW;
          end
        end
      end
      ST_ROW, ST_COL: begin
        if (t_q == last_t) begin
          t_d = '0;
          if (TW'(line_q) == lines_m1) begin
            line_d  = '0;
            state_d = col_pass ? ST_COL_FLUSH : ST_ROW_FLUSH;
          end else begin
            line_d = line_q + 1'b1;
          end
        end else begin
          t_d = t_q + 1'b1;
        end
      end
      ST_ROW_FLUSH: begin
        // let the last row write land before the column reads start
        state_d = ST_COL;
      end
      ST_COL_FLUSH: begin
        state_d     = ST_IDLE;
        done_d      = 1'b1;
        map_ready_d = 1'b1;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      t_q         <= '0;
      line_q      <= '0;
      done_q      <= 1'b0;
      map_ready_q <= 1'b0;
      infl_w_q    <= '0;
      infl_h_q    <= '0;
      r_q         <= '0;
    end else begin
      state_q     <= state_d;
      t_q         <= t_d;
      line_q      <= line_d;
      done_q      <= done_d;
      map_ready_q <= map_ready_d;
      if (start_infl) begin
        infl_w_q <= eff_w;
        infl_h_q <= eff_h;
        r_q      <= eff_r;
      end
    end
  end

  // Window stage: memory data arrives here in the cycle after the read
  logic           s1_valid_q;
  logic           s1_col_q;
  logic           s1_inb_q;
  logic [TW-1:0]  s1_t_q;
  logic [LNW-1:0] s1_line_q;
  logic [CW-1:0]  cnt_q;
  logic [CW-1:0]  cnt_cur;
  logic [CW-1:0]  cnt_nx;
  logic [CW-1:0]  far;
  logic           s1_bit;
  logic           hit;
  logic [TW-1:0]  pos;
  logic           s1_we;

  logic [0:0]    obs_rdata;
  logic [1:0]    work_rdata;
  logic [AW-1:0] work_raddr;
  logic [AW-1:0] work_waddr;
  logic [1:0]    work_wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_col_q  <= col_pass;
    s1_inb_q  <= (t_q < len);
    s1_t_q    <= t_q;
    s1_line_q <= line_q;
    if (s1_valid_q) begin
      cnt_q <= cnt_nx;
    end
  end

  // Distance since the last set cell; a window hit while within 2r
  assign far     = {r_q, 1'b1};
  assign s1_bit  = s1_inb_q && (s1_col_q ? work_rdata[1] : obs_rdata[0]);
  assign cnt_cur = (s1_t_q == '0) ? far : cnt_q;
  assign cnt_nx  = s1_bit ? '0 : ((cnt_cur >= far) ? cnt_cur : cnt_cur + 1'b1);
  assign hit     = (cnt_nx < far);
  assign pos     = s1_t_q - TW'(r_q);
  assign s1_we   = s1_valid_q && (s1_t_q >= TW'(r_q));

  assign work_waddr = s1_col_q ? {pos[YW-1:0], s1_line_q[XW-1:0]}
                               : {s1_line_q[YW-1:0], pos[XW-1:0]};
  assign work_wdata = s1_col_q ? {1'b0, hit} : {hit, 1'b0};
  assign work_raddr = col_pass ? {t_q[YW-1:0], line_q[XW-1:0]} : item_addr;

  // Obstacle bits, written by loads and read by the row pass
  odfm_ram #(
    .WIDTH (1),
    .DEPTH (2 ** AW)
  ) u_obs_ram (
    .clk_i   (clk_i),
    .we_i    (accept && (item_i.kind == KIND_LOAD) && item_in_map),
    .waddr_i (item_addr),
    .wdata_i (item_i.cell_value == OBSTACLE_VALUE),
    .raddr_i ({line_q[YW-1:0], t_q[XW-1:0]}),
    .rdata_o (obs_rdata)
  );

  // Work store: row-dilated bit above, inflated mark below
  odfm_ram #(
    .WIDTH (2),
    .DEPTH (2 ** AW)
  ) u_work_ram (
    .clk_i   (clk_i),
    .we_i    (s1_we),
    .waddr_i (work_waddr),
    .wdata_i (work_wdata),
    .raddr_i (work_raddr),
    .rdata_o (work_rdata)
  );

  // Query result
  logic       q_valid_q;
  logic       q_mask_q;
  logic       q_rng_q;
  logic       q_infl_q;
  logic [7:0] q_cost_q;
  logic [7:0] bg;
  logic [7:0] q_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_valid_q <= 1'b0;
    end else begin
      q_valid_q <= accept && (item_i.kind == KIND_QUERY);
    end
  end

  always_ff @(posedge clk_i) begin
    q_mask_q <= enable_q && map_ready_q;
    q_rng_q  <= item_in_map;
    q_infl_q <= item_in_infl;
    q_cost_q <= item_i.master_cost;
  end

  assign bg = (q_infl_q && work_rdata[0]) ? MARK_VALUE : COST_FREE;

  always_comb begin
    if (!q_mask_q) begin
      q_res = q_cost_q;
    end else if (!q_rng_q) begin
      q_res = COST_FREE;
    end else if ((q_cost_q >= LETHAL_THRESHOLD) && (bg < INFLATED_THRESHOLD)) begin
      q_res = COST_LETHAL;
    end else begin
      q_res = COST_FREE;
    end
  end

  assign res_valid_o        = q_valid_q || done_q;
  assign res_o.new_cost     = done_q ? COST_FREE : q_res;
  assign res_o.inflate_done = done_q;

endmodule

>>> rtl/odfm_ram.sv
// ----------------------------------------------------------------------------
// odfm_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module odfm_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/odfm_checker.sv
// ----------------------------------------------------------------------------
// odfm_checker
// Port-level checks of the foreground mask unit, bound to the top level.
// ----------------------------------------------------------------------------
module odfm_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start_i,
  input logic            busy_o,
  input odfm_pkg::item_t item_i,
  input logic            res_valid_o,
  input odfm_pkg::res_t  res_o
);
  import odfm_pkg::*;

  logic accept;
  assign accept = start_i && !busy_o;

  // a done word always carries a free cost
  a_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.inflate_done |-> res_o.new_cost == COST_FREE)
    else $error("inflate done word with non-free cost");

  // inflation either starts walking or finishes at once on an empty map
  a_infl_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && item_i.kind == KIND_INFLATE |=>
      busy_o || (res_valid_o && res_o.inflate_done))
    else $error("inflate item neither started nor finished");

  // loads give no word
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && item_i.kind == KIND_LOAD |=> !res_valid_o)
    else $error("load produced a result word");

  // every query answers in the next cycle
  a_query_ans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && item_i.kind == KIND_QUERY |=> res_valid_o && !res_o.inflate_done)
    else $error("query result missing");

  // the end of a walk comes with its done word
  a_busy_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> res_valid_o && res_o.inflate_done)
    else $error("inflation ended without done word");

endmodule

bind occupancy_dilate_foreground_mask_unit odfm_checker u_odfm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .item_i      (item_i),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);

>>> test/occupancy_dilate_foreground_mask_unit_test.sv
// ----------------------------------------------------------------------------
// occupancy_dilate_foreground_mask_unit_test
// Self-checking bench for the occupancy dilation foreground mask unit. Loads,
// inflations and queries are driven in bursts under several register
// settings. Every accepted item is run through a local map predictor, and
// each result word is checked against the oldest answer still owed.
// ----------------------------------------------------------------------------
module occupancy_dilate_foreground_mask_unit_test;
  import odfm_pkg::*;

  localparam int STRIDE = int'(MAX_WIDTH_DEF);
  localparam int CELLS = int'(MAX_WIDTH_DEF * MAX_HEIGHT_DEF);
  localparam int ITEM_BUDGET = 1800;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start_i = 1'b0;
  logic                  busy_o;
  item_t                 item_i = '0;
  logic                  res_valid_o;
  res_t                  res_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // Predictor state
  logic       mask_en = ENABLE_RST;
  logic [3:0] win_radius = RADIUS_RST;
  logic [8:0] width_reg = MAP_WIDTH_RST;
  logic [8:0] height_reg = MAP_HEIGHT_RST;
  bit         map_inflated = 1'b0;
  bit         obst_map [CELLS];
  bit         dilated_map [CELLS];

  res_t  answers_owed [$];
  res_t  owed;
  item_t item_backlog [$];
  int    pushed_count = 0;
  int    accepted_count = 0;
  bit    failed = 1'b0;
  bit    took = 1'b0;
  int    burst_left = 0;
  int    gap_left = 0;

  // Stimulus view of the map: which cells hold a defined value
  bit cell_loaded [CELLS];
  int gen_w = int'(MAX_WIDTH_DEF);
  int gen_h = int'(MAX_HEIGHT_DEF);

  occupancy_dilate_foreground_mask_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .item_i      (item_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int clip_size(logic [8:0] v, int lim);
    return (int'(v) > lim) ? lim : int'(v);
  endfunction

  // Raw coordinate bits compare unsigned, so negatives fall outside
  function automatic bit in_map(logic [15:0] x, logic [15:0] y, int w, int h);
    return (int'(x) < w) && (int'(y) < h);
  endfunction

  task automatic dilate_obstacles();
    int w, h, r, x, y, cx, cy;
    w = clip_size(width_reg, int'(MAX_WIDTH_DEF));
    h = clip_size(height_reg, int'(MAX_HEIGHT_DEF));
    r = (int'(win_radius) > int'(MAX_RADIUS_DEF)) ? int'(MAX_RADIUS_DEF) : int'(win_radius);
    foreach (dilated_map[i]) dilated_map[i] = 1'b0;
    // stamp the clipped square around every obstacle
    for (y = 0; y < h; y++)
      for (x = 0; x < w; x++)
        if (obst_map[y * STRIDE + x])
          for (cy = (y > r) ? y - r : 0; cy <= y + r && cy < h; cy++)
            for (cx = (x > r) ? x - r : 0; cx <= x + r && cx < w; cx++)
              dilated_map[cy * STRIDE + cx] = 1'b1;
  endtask

  task automatic mask_step(item_t it);
    res_t        ans;
    int          w, h, idx;
    logic [15:0] ux, uy;
    w = clip_size(width_reg, int'(MAX_WIDTH_DEF));
    h = clip_size(height_reg, int'(MAX_HEIGHT_DEF));
    ux = it.map_x;
    uy = it.map_y;
    idx = int'(uy) * STRIDE + int'(ux);
    case (it.kind)
      KIND_LOAD: begin
        if (in_map(ux, uy, w, h)) obst_map[idx] = (it.cell_value == OBSTACLE_VALUE);
      end
      KIND_INFLATE: begin
        dilate_obstacles();
        map_inflated = 1'b1;
        ans.new_cost = COST_FREE;
        ans.inflate_done = 1'b1;
        answers_owed.push_back(ans);
      end
      KIND_QUERY: begin
        ans.inflate_done = 1'b0;
        if (!mask_en || !map_inflated) begin
          ans.new_cost = it.master_cost;
        end else if (in_map(ux, uy, w, h)) begin
          ans.new_cost = (it.master_cost >= LETHAL_THRESHOLD && !dilated_map[idx]) ?
                         COST_LETHAL : COST_FREE;
        end else begin
          ans.new_cost = COST_FREE;
        end
        answers_owed.push_back(ans);
      end
      default: ;
    endcase
  endtask

  // Monitor: register writes, result words, accepted items
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      took = 1'b0;
    end else begin
      took = start_i && !busy_o;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_ENABLE:     mask_en = cfg_data_i[0];
          REG_RADIUS:     win_radius = cfg_data_i[3:0];
          REG_MAP_WIDTH:  width_reg = cfg_data_i;
          REG_MAP_HEIGHT: height_reg = cfg_data_i;
          default: ;
        endcase
      end
      if (res_valid_o) begin
        if (answers_owed.size() == 0) begin
          $display("%0t: unexpected word, expected none, got new_cost=%0d inflate_done=%0b",
                   $time, res_o.new_cost, res_o.inflate_done);
          failed = 1'b1;
        end else begin
          owed = answers_owed.pop_front();
          if (res_o.new_cost !== owed.new_cost) begin
            $display("%0t: new_cost expected %0d, got %0d", $time, owed.new_cost,
                     res_o.new_cost);
            failed = 1'b1;
          end
          if (res_o.inflate_done !== owed.inflate_done) begin
            $display("%0t: inflate_done expected %0b, got %0b", $time, owed.inflate_done,
                     res_o.inflate_done);
            failed = 1'b1;
          end
        end
      end
      if (took) begin
        accepted_count++;
        mask_step(item_i);
      end
    end
  end

  // Driver: hold the word while busy, otherwise advance in bursts and gaps
  always @(negedge clk_i) begin
    if (rst_ni && !(start_i && !took)) begin
      if (gap_left > 0) begin
        gap_left--;
        start_i <= 1'b0;
      end else if (item_backlog.size() > 0) begin
        item_i <= item_backlog.pop_front();
        start_i <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  task automatic queue_item(logic [1:0] k, logic [15:0] x, logic [15:0] y, logic [7:0] v,
                            logic [7:0] c);
    item_t it;
    it.kind = k;
    it.map_x = x;
    it.map_y = y;
    it.cell_value = v;
    it.master_cost = c;
    if (k == KIND_LOAD && in_map(x, y, gen_w, gen_h))
      cell_loaded[int'(y) * STRIDE + int'(x)] = 1'b1;
    item_backlog.push_back(it);
    pushed_count++;
  endtask

  function automatic logic [7:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 3) return OBSTACLE_VALUE;
    if (sel == 3) return ($urandom_range(0, 1) == 0) ? 8'd99 : 8'd101;
    return 8'($urandom);
  endfunction

  function automatic logic [15:0] pick_coord(int size);
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 17 && size > 0) return 16'($urandom_range(0, size - 1));
    if (sel == 17) return 16'(size + int'($urandom_range(0, 2)));
    if (sel == 18) return 16'(-1 - int'($urandom_range(0, 2)));
    return 16'($urandom);
  endfunction

  function automatic logic [7:0] pick_cost();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return 8'($urandom_range(86, 94));
    if (sel == 4) return 8'd0;
    if (sel == 5) return 8'd255;
    return 8'($urandom);
  endfunction

  // Load every cell of the map in use that still holds no defined value
  task automatic fill_map();
    int x, y;
    for (y = 0; y < gen_h; y++)
      for (x = 0; x < gen_w; x++)
        if (!cell_loaded[y * STRIDE + x])
          queue_item(KIND_LOAD, 16'(x), 16'(y), pick_value(), 8'($urandom));
  endtask

  task automatic inflate_map();
    fill_map();
    queue_item(KIND_INFLATE, 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic drain();
    while (accepted_count != pushed_count || answers_owed.size() != 0) @(negedge clk_i);
    // loads give no word; let the last one settle
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_config(bit en, logic [3:0] r, logic [8:0] w, logic [8:0] h);
    logic [7:0] junk;
    drain();
    junk = 8'($urandom);
    // unused upper data bits carry junk
    write_reg(REG_ENABLE, {junk, en});
    write_reg(REG_RADIUS, {junk[4:0], r});
    write_reg(REG_MAP_WIDTH, w);
    write_reg(REG_MAP_HEIGHT, h);
    gen_w = clip_size(w, int'(MAX_WIDTH_DEF));
    gen_h = clip_size(h, int'(MAX_HEIGHT_DEF));
  endtask

  task automatic run_phase(bit en, logic [3:0] r, logic [8:0] w, logic [8:0] h, int n,
                           int p_inf);
    int cnt, sel;
    set_config(en, r, w, h);
    if (p_inf > 0) inflate_map();
    cnt = 0;
    while (cnt < n) begin
      sel = $urandom_range(0, 99);
      if (sel < 3) begin
        queue_item(KIND_UNUSED, 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        cnt++;
        if (sel < 3 + p_inf)
          inflate_map();
        else if (sel < 45)
          queue_item(KIND_LOAD, pick_coord(gen_w), pick_coord(gen_h), pick_value(),
                     8'($urandom));
        else
          queue_item(KIND_QUERY, pick_coord(gen_w), pick_coord(gen_h), 8'($urandom),
                     pick_cost());
      end
    end
  endtask

  initial begin
    int i;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // nothing inflated yet: costs pass through at the reset map size
    queue_item(KIND_QUERY, 16'h0000, 16'h0000, 8'h00, 8'd255);
    queue_item(KIND_QUERY, 16'h7fff, 16'h8000, 8'h7f, 8'd0);
    queue_item(KIND_UNUSED, 16'hffff, 16'h1234, 8'h80, 8'd254);

    // 4 x 3 map, obstacles in opposite corners, radius 1
    set_config(1'b1, 4'd1, 9'd4, 9'd3);
    for (i = 0; i < 12; i++)
      queue_item(KIND_LOAD, 16'(i % 4), 16'(i / 4),
                 (i == 0 || i == 11) ? OBSTACLE_VALUE :
                 (i == 1) ? 8'h80 : (i == 2) ? 8'h7f : (i == 3) ? 8'd99 :
                 (i == 4) ? 8'd101 : 8'(i * 37), 8'($urandom));
    // loads just outside the map are dropped
    queue_item(KIND_LOAD, 16'd4, 16'd0, OBSTACLE_VALUE, 8'd0);
    queue_item(KIND_LOAD, 16'hffff, 16'd1, OBSTACLE_VALUE, 8'd0);
    queue_item(KIND_LOAD, 16'd0, 16'd3, OBSTACLE_VALUE, 8'd0);
    queue_item(KIND_INFLATE, 16'd0, 16'd0, 8'd0, 8'd0);
    queue_item(KIND_QUERY, 16'd1, 16'd1, 8'd0, 8'd254);
    queue_item(KIND_QUERY, 16'd2, 16'd0, 8'd0, 8'd90);
    queue_item(KIND_QUERY, 16'd2, 16'd0, 8'd0, 8'd89);
    queue_item(KIND_QUERY, 16'd3, 16'd0, 8'd0, 8'd255);
    queue_item(KIND_QUERY, 16'h7fff, 16'd0, 8'd0, 8'd255);
    queue_item(KIND_QUERY, 16'd0, 16'h8000, 8'd0, 8'd255);

    run_phase(1'b1, 4'd2, 9'd8, 9'd8, 80, 6);
    run_phase(1'b1, 4'd0, 9'd16, 9'd16, 80, 6);
    run_phase(1'b1, 4'd15, 9'd16, 9'd12, 80, 6);
    run_phase(1'b0, 4'd3, 9'd8, 9'd8, 60, 8);
    run_phase(1'b1, 4'd5, 9'd256, 9'd1, 60, 4);
    run_phase(1'b1, 4'd15, 9'd1, 9'd256, 60, 4);
    // sizes beyond the maximum saturate
    run_phase(1'b1, 4'd4, 9'd511, 9'd1, 40, 4);
    run_phase(1'b1, 4'd2, 9'd1, 9'd300, 40, 4);
    // empty maps
    run_phase(1'b1, 4'd3, 9'd0, 9'd8, 40, 8);
    run_phase(1'b1, 4'd3, 9'd5, 9'd0, 30, 8);
    // shrink, then grow, without inflating again
    run_phase(1'b1, 4'd7, 9'd12, 9'd10, 80, 8);
    run_phase(1'b1, 4'd7, 9'd6, 9'd5, 40, 0);
    run_phase(1'b1, 4'd7, 9'd16, 9'd16, 40, 0);

    while (pushed_count < ITEM_BUDGET)
      run_phase($urandom_range(0, 7) != 0,
                ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) :
                                              4'($urandom_range(0, 3)),
                9'($urandom_range(1, 16)), 9'($urandom_range(1, 16)),
                $urandom_range(50, 100), $urandom_range(3, 8));

    drain();
    if (failed)
      $display("simulation failed");
    else
      $display("simulation ok");
    $finish;
  end

  initial begin
    #20000000;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> filelist.f
rtl/odfm_pkg.sv
rtl/odfm_ram.sv
rtl/occupancy_dilate_foreground_mask_unit.sv
rtl/odfm_checker.sv
test/occupancy_dilate_foreground_mask_unit_test.sv
